### hw/rtl/dmc_pkg.sv
// Package for the direct-mapped write-back cache block.
// Holds address split widths, memory geometry, the queued request type and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int ADDR_W          = 16;
  localparam int TAG_W           = 8;
  localparam int LINE_W          = 5;
  localparam int OFF_W           = 3;
  localparam int BYTE_W          = 8;
  localparam int NUM_LINES       = 1 << LINE_W;
  localparam int LINE_BYTES      = 1 << OFF_W;
  localparam int ROW_W           = LINE_BYTES * BYTE_W;
  localparam int MEM_ROW_W       = TAG_W + LINE_W;
  localparam int MEM_ROWS        = 1 << MEM_ROW_W;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
    logic [OFF_W-1:0]  off;
    op_t               op;
    logic [BYTE_W-1:0] wdata;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_APPLY
  } back_state_t;

endpackage

### hw/rtl/dmc_front.sv
// Front end: accepts input requests, splits the address and holds them in a short queue.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_front
  import dmc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // address[15:0], write_data[23:16]
  input  logic [0:0]          s_axis_tuser,  // opcode[0]
  input  back_status_t        status,
  output logic                cmd_valid,
  output cmd_t                cmd,
  input  logic                cmd_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  cmd_t             decoded;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    decoded.tag   = s_axis_tdata[ADDR_W-1 -: TAG_W];
    decoded.line  = s_axis_tdata[OFF_W +: LINE_W];
    decoded.off   = s_axis_tdata[OFF_W-1:0];
    decoded.op    = op_t'(s_axis_tuser[0]);
    decoded.wdata = s_axis_tdata[ADDR_W +: BYTE_W];
  end

  assign s_axis_tready = !status.clearing && (count != CNT_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (count != '0);
  assign cmd           = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (cmd_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

endmodule

### hw/rtl/dmc_back.sv
// Back end: cache lookup, eviction, line fill, byte access and result register.
// Holds the cache line store, tags, dirty flags and the row-wide backing memory.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_back
  import dmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output back_status_t       status,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // read_data[7:0]
  output logic [1:0]         m_axis_tuser   // hit[0], dirty[1]
);

  back_state_t state, state_next;

  logic [ROW_W-1:0]     cache_mem [NUM_LINES];
  logic [ROW_W-1:0]     cache_q;
  logic [ROW_W-1:0]     mem [MEM_ROWS];
  logic [ROW_W-1:0]     mem_q;
  logic [TAG_W-1:0]     tags [NUM_LINES];
  logic [NUM_LINES-1:0] dirty;
  logic [NUM_LINES-1:0] cvalid;
  logic [MEM_ROW_W-1:0] clr_cnt;

  cmd_t              cur;
  logic              cur_hit;
  logic              cur_dirty;
  logic [ROW_W-1:0]  line_buf;
  logic              out_valid;
  logic [BYTE_W-1:0] out_data;
  logic              out_hit;
  logic              out_dirty;

  logic                 clr_done;
  logic [ROW_W-1:0]     row_now;
  logic                 hit_now;
  logic [ROW_W-1:0]     merged;
  logic                 is_write;
  logic                 deliver;
  logic                 apply_done;
  logic                 cache_we;
  logic [ROW_W-1:0]     cache_wdata;
  logic                 mem_we;
  logic [MEM_ROW_W-1:0] mem_waddr;
  logic [ROW_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [MEM_ROW_W-1:0] mem_raddr;

  assign clr_done = (clr_cnt == MEM_ROW_W'(MEM_ROWS - 1));
  assign row_now  = cvalid[cur.line] ? cache_q : '0;
  assign hit_now  = (tags[cur.line] == cur.tag);
  assign is_write = (cur.op == OP_WRITE);

  always_comb begin
    merged = line_buf;
    merged[{cur.off, 3'b000} +: BYTE_W] = cur.wdata;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = hit_now ? ST_APPLY : ST_FILL;
      end
      ST_FILL: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    status.clearing = 1'b0;
    cmd_pop         = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = {tags[cur.line], cur.line};
    mem_wdata       = row_now;
    mem_re          = 1'b0;
    mem_raddr       = {cur.tag, cur.line};
    deliver         = 1'b0;
    apply_done      = 1'b0;
    cache_we        = 1'b0;
    cache_wdata     = is_write ? merged : line_buf;
    case (state)
      ST_CLEAR: begin
        status.clearing = 1'b1;
        mem_we          = 1'b1;
        mem_waddr       = clr_cnt;
        mem_wdata       = '0;
      end
      ST_IDLE: begin
        cmd_pop = cmd_valid;
      end
      ST_LOOKUP: begin
        mem_we = !hit_now;
        mem_re = !hit_now;
      end
      ST_FILL: begin
      end
      ST_APPLY: begin
        deliver    = !is_write && (!out_valid || m_axis_tready);
        apply_done = is_write || deliver;
        cache_we   = apply_done && (is_write || !cur_hit);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      dirty     <= '1;
      cvalid    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        tags[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_FILL) begin
        tags[cur.line] <= cur.tag;
      end
      if (cache_we) begin
        cvalid[cur.line] <= 1'b1;
      end
      if (apply_done && (is_write || !cur_hit)) begin
        dirty[cur.line] <= is_write;
      end
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == ST_LOOKUP) begin
      cur_hit   <= hit_now;
      cur_dirty <= dirty[cur.line];
      line_buf  <= row_now;
    end
    if (state == ST_FILL) begin
      line_buf <= mem_q;
    end
    if (deliver) begin
      out_data  <= line_buf[{cur.off, 3'b000} +: BYTE_W];
      out_hit   <= cur_hit;
      out_dirty <= cur_dirty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cache_q <= cache_mem[cmd.line];
    end
    if (cache_we) begin
      cache_mem[cur.line] <= cache_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = {out_dirty, out_hit};

endmodule

### hw/rtl/direct_mapped_cache_with_memory.sv
// Top level of the direct-mapped write-back cache with its 64K-byte backing memory.
// Instantiates dmc_front and dmc_back; depends on dmc_pkg.
//
//   channel | dir | tdata                          | tuser
//   s_axis  | in  | address[15:0] write_data[23:16] | opcode[0]
//   m_axis  | out | read_data[7:0]                 | hit[0] dirty[1]
//
// A hit runs the back FSM steps pop, tag check, byte access; a miss adds a fill step:
// in tag check the old line goes to memory as the new row is read, one row per port.
// After reset the backing memory is cleared one 8-byte row a cycle, all 8192 rows,
// with s_axis_tready low. A read waits in the byte access step while the result
// register is full and m_axis_tready is low; the queue still takes requests until full.
`timescale 1ns / 1ps

module direct_mapped_cache_with_memory
  import dmc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_data[7:0]
  output logic [1:0]  m_axis_tuser    // hit[0], dirty[1]
);

  logic         cmd_valid;
  cmd_t         cmd;
  logic         cmd_pop;
  back_status_t status;

  dmc_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .status        (status),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  dmc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !s_axis_tready)
    else $error("request accepted during memory clear");

  a_pop_only_when_queued: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("queue popped while empty");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !m_axis_tvalid)
    else $error("result shown during memory clear");

  a_clear_then_idle_queue: assert property (@(posedge clk) disable iff (rst)
    status.clearing |=> (status.clearing || !cmd_valid))
    else $error("queue filled during memory clear");

endmodule

### tb/tb_direct_mapped_cache_with_memory.sv
// Self-checking bench for direct_mapped_cache_with_memory: directed and random byte requests,
// with results checked against a local cache-and-memory model under random stalls and in a stall-free phase.
// Depends on dmc_pkg and the cache RTL.
`timescale 1ns / 1ps

module tb_direct_mapped_cache_with_memory;
  import dmc_pkg::*;

  typedef struct {
    logic [7:0] read_data;
    logic       hit;
    logic       dirty;
  } read_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // address[15:0], write_data[23:16]
  logic [0:0]  s_axis_tuser = '0;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // read_data[7:0]
  logic [1:0]  m_axis_tuser;        // hit[0], dirty[1]

  logic [7:0] model_lines [0:255];
  logic [7:0] model_tags  [0:31];
  logic       model_dirty [0:31];
  logic [7:0] model_memory [0:65535];

  read_result_t pending_reads[$];
  int  error_count = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  rx_stall_left = 0;

  direct_mapped_cache_with_memory dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void predict_access(input logic [15:0] addr, input op_t op,
                                         input logic [7:0] data);
    logic [7:0]   tag;
    logic [4:0]   line;
    logic [2:0]   off;
    logic         was_hit;
    logic         was_dirty;
    read_result_t r;
    tag       = addr[15:8];
    line      = addr[7:3];
    off       = addr[2:0];
    was_hit   = (model_tags[line] == tag);
    was_dirty = model_dirty[line];
    if (!was_hit) begin
      for (int i = 0; i < 8; i++)
        model_memory[{model_tags[line], line, i[2:0]}] = model_lines[{line, i[2:0]}];
      for (int i = 0; i < 8; i++)
        model_lines[{line, i[2:0]}] = model_memory[{tag, line, i[2:0]}];
      model_tags[line] = tag;
    end
    if (op == OP_WRITE) begin
      model_lines[{line, off}] = data;
      model_dirty[line] = 1'b1;
    end else begin
      if (!was_hit) model_dirty[line] = 1'b0;
      r.read_data = model_lines[{line, off}];
      r.hit       = was_hit;
      r.dirty     = was_dirty;
      pending_reads.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    int r;
    if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    read_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        report_error($sformatf("unexpected result data=%h hit=%b dirty=%b",
                               m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]));
      end else begin
        want = pending_reads.pop_front();
        if (m_axis_tdata !== want.read_data || m_axis_tuser[0] !== want.hit ||
            m_axis_tuser[1] !== want.dirty)
          report_error($sformatf("expected data=%h hit=%b dirty=%b, got data=%h hit=%b dirty=%b",
                                 want.read_data, want.hit, want.dirty,
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]));
      end
    end
  end

  task automatic send_request(input logic [15:0] addr, input op_t op, input logic [7:0] data);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predict_access(addr, op, data);
  endtask

  task automatic test_reset_state();
    send_request(16'h0000, OP_READ, 8'h00);
    send_request(16'h00FF, OP_READ, 8'hFF);
  endtask

  task automatic test_write_allocate();
    send_request(16'hFFFF, OP_WRITE, 8'hFF);
    send_request(16'hFFFF, OP_READ, 8'h00);
    send_request(16'hFFF8, OP_WRITE, 8'h5A);
  endtask

  task automatic test_conflict_evict();
    send_request(16'h00FF, OP_READ, 8'h00);
    send_request(16'hFFFF, OP_READ, 8'h00);
    send_request(16'hFFF8, OP_READ, 8'h00);
  endtask

  task automatic test_clean_evict();
    send_request(16'h1208, OP_READ, 8'h00);
    send_request(16'h0008, OP_READ, 8'h00);
    send_request(16'h1209, OP_READ, 8'h00);
    send_request(16'h0008, OP_WRITE, 8'h00);
  endtask

  task automatic test_field_extremes();
    send_request(16'h8000, OP_WRITE, 8'h80);
    send_request(16'h7FFF, OP_WRITE, 8'h7F);
    send_request(16'h8000, OP_READ, 8'h00);
    send_request(16'h7FFF, OP_READ, 8'h00);
    send_request(16'h5555, OP_WRITE, 8'h55);
    send_request(16'hAAAA, OP_READ, 8'hAA);
    send_request(16'hAAAA, OP_WRITE, 8'hAA);
    send_request(16'hAAAA, OP_READ, 8'h00);
    send_request(16'h5555, OP_READ, 8'h00);
    send_request(16'h0008, OP_READ, 8'h00);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_random_mixed(input int count, input bit steady);
    logic [7:0]  tag_pool [4];
    logic [4:0]  line_base;
    logic [15:0] addr;
    op_t         op;
    tx_steady = steady;
    rx_steady <= steady;
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0) begin
        foreach (tag_pool[k]) tag_pool[k] = 8'($urandom_range(0, 255));
        line_base = 5'($urandom_range(0, 31));
      end
      if ($urandom_range(0, 99) < 70)
        addr = {tag_pool[$urandom_range(0, 3)], 5'(line_base + $urandom_range(0, 3)),
                3'($urandom_range(0, 7))};
      else
        addr = 16'($urandom);
      op = ($urandom_range(0, 99) < 55) ? OP_READ : OP_WRITE;
      send_request(addr, op, 8'($urandom));
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    int spins;
    for (int i = 0; i < 256; i++) model_lines[i] = 8'h00;
    for (int i = 0; i < 32; i++) begin
      model_tags[i]  = 8'h00;
      model_dirty[i] = 1'b1;
    end
    for (int i = 0; i < 65536; i++) model_memory[i] = 8'h00;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_write_allocate();
    test_conflict_evict();
    test_clean_evict();
    test_field_extremes();
    test_random_mixed(600, 1'b0);
    hold_until_drained();
    test_random_mixed(200, 1'b1);
    test_random_mixed(800, 1'b0);

    s_axis_tvalid <= 1'b0;
    spins = 0;
    while (pending_reads.size() != 0 && spins < 100000) begin
      @(posedge clk);
      spins++;
    end
    repeat (40) @(posedge clk);
    if (pending_reads.size() != 0)
      report_error($sformatf("%0d expected results never arrived", pending_reads.size()));

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_front.sv
hw/rtl/dmc_back.sv
hw/rtl/direct_mapped_cache_with_memory.sv
tb/tb_direct_mapped_cache_with_memory.sv
